FILE: design/top_k_sorted_score_table_macros.svh
// Assertion macros for the top-K score table.
// Used by the top level; no other dependencies.
`ifndef TOP_K_SORTED_SCORE_TABLE_MACROS_SVH
`define TOP_K_SORTED_SCORE_TABLE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define TKST_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define TKST_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TKST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/tkst_pkg.sv
// Shared types and codes for the top-K score table.
// No dependencies; used by tkst_cell and top_k_sorted_score_table.
package tkst_pkg;

	localparam int ScoreW = 32;
	localparam int TagW   = 16;
	localparam int IndexW = 4;
	localparam int CountW = 4;

	// Request action codes
	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// One list entry
	typedef struct packed {
		logic [ScoreW-1:0] score;
		logic [TagW-1:0]   tag;
	} entry_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic load_en;  // an insert happens this cycle
		logic below_n;  // cell position is below the effective count
	} cell_ctrl_t;

endpackage

FILE: design/tkst_cell.sv
// One compare-and-shift cell of the top-K score table.
// Depends on tkst_pkg.
module tkst_cell (
	input  logic                clk,
	input  tkst_pkg::cell_ctrl_t ctrl,
	input  tkst_pkg::entry_t    new_entry,
	input  tkst_pkg::entry_t    prev_entry,
	input  logic                prev_mark,
	output tkst_pkg::entry_t    entry,
	output logic                mark
);

	tkst_pkg::entry_t entry_q;

	// Mark: this cell is at or after the insert position
	always_comb begin
		if (ctrl.below_n) begin
			mark = $signed(new_entry.score) > $signed(entry_q.score);
		end else begin
			mark = 1'b1;
		end
	end

	// Shift from the neighbor, take the new entry, or hold
	always_ff @(posedge clk) begin
		if (ctrl.load_en && mark) begin
			if (prev_mark) begin
				entry_q <= prev_entry;
			end else begin
				entry_q <= new_entry;
			end
		end
	end

	assign entry = entry_q;

endmodule

FILE: design/top_k_sorted_score_table.sv
// Top level of the top-K score table: cell chain, count, read select, output register.
// Depends on tkst_pkg, tkst_cell and top_k_sorted_score_table_macros.svh.

// Keeps up to CAPACITY (score, tag) entries in descending score order in a row of
// cells, one entry per cell. A request is add, read, clear or none; each yields one
// result carrying the entry count after the request. The block takes one request per
// clock while the output slot is free or draining; the cell chain finds the insert
// position by comparing against each held score and shifts as the request is taken;
// the result appears in the output register on the next cycle. A new request is taken
// while the held result is being taken in the same cycle. No clearing pass: the count
// alone marks which cells hold entries.
`include "top_k_sorted_score_table_macros.svh"

module top_k_sorted_score_table #(
	parameter int CAPACITY = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic signed [tkst_pkg::ScoreW-1:0] score,
	input  logic [tkst_pkg::TagW-1:0]          name_tag,
	input  logic [tkst_pkg::IndexW-1:0]        entry_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic                               entry_found,
	output logic signed [tkst_pkg::ScoreW-1:0] entry_score,
	output logic [tkst_pkg::TagW-1:0]          entry_tag,
	output logic [tkst_pkg::CountW-1:0]        entry_count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > tkst_pkg::IndexW) ? CW : tkst_pkg::IndexW;
	localparam int WIDEW = (CMPW > tkst_pkg::CountW) ? CMPW : tkst_pkg::CountW;

	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic          accepted_q;
	logic          found_q;
	logic [tkst_pkg::ScoreW-1:0] rscore_q;
	logic [tkst_pkg::TagW-1:0]   rtag_q;

	tkst_pkg::action_t    act;
	tkst_pkg::entry_t     new_entry;
	tkst_pkg::entry_t     cell_entry [CAPACITY];
	logic                 cell_mark  [CAPACITY];
	tkst_pkg::cell_ctrl_t cell_ctrl  [CAPACITY];

	logic          fire;
	logic          full;
	logic [CW-1:0] n_eff;
	logic          add_ok;
	logic          insert_en;
	logic [CW-1:0] count_d;
	logic [CMPW-1:0] idx_ext;
	logic          idx_ok;
	tkst_pkg::entry_t read_entry;

	assign act       = tkst_pkg::action_t'(action);
	assign new_entry = '{score: score, tag: name_tag};

	// Handshake: accept while the output slot is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	// Add decision
	assign full   = (count_q >= CW'(CAPACITY));
	assign n_eff  = full ? CW'(CAPACITY - 1) : count_q;
	assign add_ok = (score > 0) &&
		(!full || (score > $signed(cell_entry[CAPACITY-1].score)));
	assign insert_en = fire && (act == tkst_pkg::ACT_ADD) && add_ok;

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_ctrl[i].load_en = insert_en;
		assign cell_ctrl[i].below_n = (CW'(i) < n_eff);
		if (i == 0) begin : g_head
			tkst_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.new_entry  (new_entry),
				.prev_entry (new_entry),
				.prev_mark  (1'b0),
				.entry      (cell_entry[i]),
				.mark       (cell_mark[i])
			);
		end else begin : g_body
			tkst_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.new_entry  (new_entry),
				.prev_entry (cell_entry[i-1]),
				.prev_mark  (cell_mark[i-1]),
				.entry      (cell_entry[i]),
				.mark       (cell_mark[i])
			);
		end
	end

	// Read select over the cells
	assign idx_ext = CMPW'(entry_index);
	assign idx_ok  = (idx_ext < CMPW'(count_q)) && (idx_ext < CMPW'(CAPACITY));

	always_comb begin
		read_entry = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			if (idx_ext == CMPW'(j)) begin
				read_entry = read_entry | cell_entry[j];
			end
		end
	end

	// Next count
	always_comb begin
		count_d = count_q;
		if (fire) begin
			unique case (act)
				tkst_pkg::ACT_ADD: begin
					if (add_ok) begin
						count_d = n_eff + 1'b1;
					end
				end
				tkst_pkg::ACT_CLEAR: count_d = '0;
				tkst_pkg::ACT_READ,
				tkst_pkg::ACT_NONE: count_d = count_q;
				default: count_d = count_q;
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q <= insert_en;
			found_q    <= (act == tkst_pkg::ACT_READ) && idx_ok;
			if ((act == tkst_pkg::ACT_READ) && idx_ok) begin
				rscore_q <= read_entry.score;
				rtag_q   <= read_entry.tag;
			end else begin
				rscore_q <= '0;
				rtag_q   <= '0;
			end
		end
	end

	logic [WIDEW-1:0] count_wide;
	assign count_wide = WIDEW'(count_q);

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign entry_found = found_q;
	assign entry_score = $signed(rscore_q);
	assign entry_tag   = rtag_q;
	assign entry_count = count_wide[tkst_pkg::CountW-1:0];

	// Checks
	`TKST_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
	`TKST_ASSERT_IMPLIES(a_acc_not_found, out_valid && accepted, !entry_found, "add result flagged found")
	`TKST_ASSERT_NEXT(a_insert_grows, insert_en && !full, count_q == CW'($past(count_q) + 1'b1), "insert did not grow count")

endmodule
